// ===== hdl/fdj_pkg.sv =====
// ----------------------------------------------------------------------------
// fdj_pkg
// Shared types and constants of the frame timestamp de-jitter core.
// ----------------------------------------------------------------------------
`default_nettype none

package fdj_pkg;

    localparam int TIME_W  = 48;   // Q16 ms timestamps
    localparam int INTV_W  = 32;   // interval estimate, Q16 ms
    localparam int FRAME_W = 16;
    localparam int MOD_W   = 17;
    localparam int CFG_IDX_W = 2;
    localparam int CFG_DATA_W = 48;

    // divider: 48-bit dividend, 17-bit divisor
    localparam int DIVD_W  = 48;
    localparam int DIVS_W  = 17;
    localparam int ITER_W  = 6;

    localparam logic ACT_FRAME = 1'b0;
    localparam logic ACT_INIT  = 1'b1;

    localparam logic [CFG_IDX_W-1:0] CFG_NOMINAL_INTERVAL = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_FRAME_MODULUS    = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_START_CLOCK      = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_START_TIMESTAMP  = 2'd3;

    typedef struct packed {
        logic [FRAME_W-1:0] frame;
        logic [TIME_W-1:0]  ftime;
        logic [TIME_W-1:0]  ctime;
    } hist_entry_t;

    typedef struct packed {
        logic              start;
        logic [DIVD_W-1:0] dividend;   // MSB-aligned to the iteration count
        logic [DIVS_W-1:0] divisor;
        logic [ITER_W-1:0] iters;
    } div_req_t;

    typedef struct packed {
        logic              done;
        logic [DIVD_W-1:0] quotient;
        logic [DIVS_W-1:0] remainder;
    } div_rsp_t;

endpackage

`default_nettype wire

// ===== hdl/frame_timestamp_dejitter_core.sv =====
// ----------------------------------------------------------------------------
// frame_timestamp_dejitter_core
// Assigns low-jitter timestamps to numbered frames from a history ring.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid/in_stall) carries action, frame_number, now_time.
//   action = initialize clears the history and loads the nominal interval;
//   it produces no result. A frame arrival produces one result on the output
//   channel (out_valid/out_stall): frame_time and the repeated flag.
//   Configuration registers are written through cfg_wr_en/cfg_index/
//   cfg_wr_data while no item is in flight.
//   One item at a time: in_stall is high from acceptance until the result is
//   loaded into the output register. The empty, single-entry and repeat
//   cases skip the serial divider; otherwise it computes the interval
//   estimate, preceded by two modulo reductions when a frame modulus is set.
//   The output register holds the result while out_stall is high; the next
//   item is accepted meanwhile and waits at its end until the register frees.
//   Reset empties the history and clears the interval and the registers.
// ----------------------------------------------------------------------------
`default_nettype none

module frame_timestamp_dejitter_core #(
    parameter int HISTORY_LEN = 64
) (
    input  wire logic                             clk,
    input  wire logic                             rst_n,
    input  wire logic                             cfg_wr_en,
    input  wire logic [fdj_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  wire logic [fdj_pkg::CFG_DATA_W-1:0]   cfg_wr_data,
    input  wire logic                             in_valid,
    output logic                                  in_stall,
    input  wire logic                             action,
    input  wire logic [fdj_pkg::FRAME_W-1:0]      frame_number,
    input  wire logic [fdj_pkg::TIME_W-1:0]       now_time,
    output logic                                  out_valid,
    input  wire logic                             out_stall,
    output logic [fdj_pkg::TIME_W-1:0]            frame_time,
    output logic                                  repeated
);
    import fdj_pkg::*;

    localparam int CNT_W  = $clog2(HISTORY_LEN+1);
    localparam int MAP_W  = TIME_W + 2;
    localparam int GAP_W  = FRAME_W + 2;
    localparam int PROD_W = INTV_W + 1 + GAP_W;
    localparam int SPAN_W = TIME_W + 1;

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_MAP   = 3'd1;
    localparam logic [2:0] S_CASE  = 3'd2;
    localparam logic [2:0] S_GAPW  = 3'd3;
    localparam logic [2:0] S_SPANW = 3'd4;
    localparam logic [2:0] S_PREP  = 3'd5;
    localparam logic [2:0] S_DIVW  = 3'd6;
    localparam logic [2:0] S_PUSH  = 3'd7;

    localparam logic [ITER_W-1:0] ITERS_MOD  = ITER_W'(DIVS_W);
    localparam logic [ITER_W-1:0] ITERS_INTV = ITER_W'(DIVD_W);

    // configuration
    logic [INTV_W-1:0]  nominal_reg;
    logic [MOD_W-1:0]   modulus_reg;
    logic [TIME_W-1:0]  start_clock_reg;
    logic [TIME_W-1:0]  start_ts_reg;

    logic [2:0]         state_reg;
    logic [INTV_W-1:0]  interval_reg;

    logic [FRAME_W-1:0] fn_reg;
    logic [TIME_W-1:0]  now_reg;
    logic [TIME_W-1:0]  clk_time_reg;
    logic [FRAME_W-1:0] lastf_reg;
    logic [TIME_W-1:0]  lat_ft_reg;
    logic [TIME_W-1:0]  lat_ct_reg;
    logic signed [GAP_W-1:0]  gap_reg;
    logic signed [GAP_W-1:0]  span_reg;
    logic               neg_reg;
    logic signed [PROD_W-1:0] prod_reg;
    logic [TIME_W-1:0]  res_time_reg;
    logic               res_rep_reg;
    logic               push_reg;

    logic               out_valid_reg;
    logic [TIME_W-1:0]  out_time_reg;
    logic               out_rep_reg;

    logic               in_xfer;
    logic               out_free;
    logic               hist_clear;
    logic               hist_push;
    hist_entry_t        entry_in;
    hist_entry_t        rd_entry;
    logic [CNT_W-1:0]   hist_cnt;
    div_req_t           dreq;
    div_rsp_t           drsp;

    logic signed [MAP_W-1:0]  map_sum;
    logic [TIME_W-1:0]        map_clamped;
    logic signed [GAP_W-1:0]  gap_plain;
    logic signed [GAP_W-1:0]  span_plain;
    logic signed [GAP_W-1:0]  gap_wrap;
    logic signed [GAP_W-1:0]  span_wrap;
    logic signed [GAP_W-1:0]  rem_signed;
    logic [DIVS_W-1:0]        span_div;
    logic signed [SPAN_W-1:0] cspan;
    logic [TIME_W-1:0]        cspan_pos;
    logic signed [PROD_W-1:0] t_sum;
    logic [TIME_W-1:0]        ft_calc;

    assign in_xfer    = in_valid && !in_stall;
    assign in_stall   = (state_reg != S_IDLE);
    assign out_free   = !out_valid_reg || !out_stall;
    assign hist_clear = in_xfer && (action == ACT_INIT);
    assign hist_push  = (state_reg == S_PUSH) && out_free && push_reg;

    assign entry_in.frame = fn_reg;
    assign entry_in.ftime = res_time_reg;
    assign entry_in.ctime = clk_time_reg;

    fdj_hist #(
        .HISTORY_LEN (HISTORY_LEN)
    ) u_hist (
        .clk         (clk),
        .rst_n       (rst_n),
        .clear       (hist_clear),
        .push        (hist_push),
        .push_entry  (entry_in),
        .rd_earliest (state_reg != S_IDLE),
        .rd_entry    (rd_entry),
        .count       (hist_cnt)
    );

    fdj_div u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (dreq),
        .rsp   (drsp)
    );

    always_comb
    begin
        // clock mapping, held to the 48-bit range
        map_sum = $signed({2'b00, start_ts_reg}) + $signed({2'b00, now_reg})
                - $signed({2'b00, start_clock_reg});
        if (map_sum < 0)
            map_clamped = '0;
        else if (map_sum[MAP_W-1:TIME_W] != '0)
            map_clamped = '1;
        else
            map_clamped = map_sum[TIME_W-1:0];

        gap_plain  = $signed({2'b00, fn_reg}) - $signed({2'b00, lastf_reg});
        span_plain = $signed({2'b00, lastf_reg}) - $signed({2'b00, rd_entry.frame});
        gap_wrap   = gap_plain + $signed({1'b0, modulus_reg});
        span_wrap  = span_plain + $signed({1'b0, modulus_reg});

        // remainder takes the sign of the dividend (truncating modulo)
        rem_signed = neg_reg ? -$signed({1'b0, drsp.remainder})
                             : $signed({1'b0, drsp.remainder});

        span_div = (span_reg <= 0) ? DIVS_W'(1) : span_reg[DIVS_W-1:0];
        cspan    = $signed({1'b0, lat_ct_reg}) - $signed({1'b0, rd_entry.ctime});
        cspan_pos = (cspan < 0) ? '0 : cspan[TIME_W-1:0];

        t_sum = $signed({{(PROD_W-TIME_W){1'b0}}, lat_ft_reg}) + prod_reg;
        if (t_sum < 0)
            ft_calc = '0;
        else if (t_sum > $signed({{(PROD_W-TIME_W){1'b0}}, clk_time_reg}))
            ft_calc = clk_time_reg;
        else
            ft_calc = t_sum[TIME_W-1:0];

        dreq = '0;
        unique case (state_reg)
            S_CASE:
            begin
                dreq.start    = (hist_cnt > CNT_W'(1)) && (lastf_reg != fn_reg)
                              && (modulus_reg != '0);
                dreq.dividend = {(gap_wrap < 0) ? DIVS_W'(-gap_wrap)
                                                : DIVS_W'(gap_wrap),
                                 {(DIVD_W-DIVS_W){1'b0}}};
                dreq.divisor  = modulus_reg;
                dreq.iters    = ITERS_MOD;
            end
            S_GAPW:
            begin
                dreq.start    = drsp.done;
                dreq.dividend = {(span_wrap < 0) ? DIVS_W'(-span_wrap)
                                                 : DIVS_W'(span_wrap),
                                 {(DIVD_W-DIVS_W){1'b0}}};
                dreq.divisor  = modulus_reg;
                dreq.iters    = ITERS_MOD;
            end
            S_PREP:
            begin
                dreq.start    = 1'b1;
                dreq.dividend = cspan_pos;
                dreq.divisor  = span_div;
                dreq.iters    = ITERS_INTV;
            end
            default:
            begin
                dreq = '0;
            end
        endcase
    end

    // configuration writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            nominal_reg     <= '0;
            modulus_reg     <= '0;
            start_clock_reg <= '0;
            start_ts_reg    <= '0;
        end
        else if (cfg_wr_en)
        begin
            unique case (cfg_index)
                CFG_NOMINAL_INTERVAL: nominal_reg     <= cfg_wr_data[INTV_W-1:0];
                CFG_FRAME_MODULUS:    modulus_reg     <= cfg_wr_data[MOD_W-1:0];
                CFG_START_CLOCK:      start_clock_reg <= cfg_wr_data[TIME_W-1:0];
                CFG_START_TIMESTAMP:  start_ts_reg    <= cfg_wr_data[TIME_W-1:0];
                default: ;
            endcase
        end
    end

    // sequencer and control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            interval_reg  <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (out_valid_reg && !out_stall)
                out_valid_reg <= 1'b0;

            unique case (state_reg)
                S_IDLE:
                begin
                    if (in_xfer)
                    begin
                        if (action == ACT_INIT)
                            interval_reg <= nominal_reg;
                        else
                            state_reg <= S_MAP;
                    end
                end
                S_MAP:
                    state_reg <= S_CASE;
                S_CASE:
                begin
                    if (hist_cnt <= CNT_W'(1) || lastf_reg == fn_reg)
                        state_reg <= S_PUSH;
                    else if (modulus_reg != '0)
                        state_reg <= S_GAPW;
                    else
                        state_reg <= S_PREP;
                end
                S_GAPW:
                begin
                    if (drsp.done)
                        state_reg <= S_SPANW;
                end
                S_SPANW:
                begin
                    if (drsp.done)
                        state_reg <= S_PREP;
                end
                S_PREP:
                    state_reg <= S_DIVW;
                S_DIVW:
                begin
                    if (drsp.done)
                    begin
                        state_reg <= S_PUSH;
                        if (drsp.quotient[DIVD_W-1:INTV_W] != '0)
                            interval_reg <= '1;
                        else
                            interval_reg <= drsp.quotient[INTV_W-1:0];
                    end
                end
                S_PUSH:
                begin
                    if (out_free)
                    begin
                        out_valid_reg <= 1'b1;
                        state_reg     <= S_IDLE;
                    end
                end
                default:
                    state_reg <= S_IDLE;
            endcase
        end
    end

    // datapath registers
    always_ff @(posedge clk)
    begin
        unique case (state_reg)
            S_IDLE:
            begin
                fn_reg  <= frame_number;
                now_reg <= now_time;
            end
            S_MAP:
            begin
                clk_time_reg <= map_clamped;
                lastf_reg    <= rd_entry.frame;
                lat_ft_reg   <= rd_entry.ftime;
                lat_ct_reg   <= rd_entry.ctime;
            end
            S_CASE:
            begin
                gap_reg  <= gap_plain;
                span_reg <= span_plain;
                neg_reg  <= (gap_wrap < 0);
                if (hist_cnt == '0)
                begin
                    res_time_reg <= clk_time_reg;
                    res_rep_reg  <= 1'b0;
                    push_reg     <= 1'b1;
                end
                else if (hist_cnt == CNT_W'(1))
                begin
                    res_time_reg <= clk_time_reg;
                    res_rep_reg  <= (lastf_reg == fn_reg);
                    push_reg     <= (lastf_reg != fn_reg);
                end
                else
                begin
                    res_time_reg <= lat_ft_reg;
                    res_rep_reg  <= (lastf_reg == fn_reg);
                    push_reg     <= (lastf_reg != fn_reg);
                end
            end
            S_GAPW:
            begin
                if (drsp.done)
                begin
                    gap_reg <= rem_signed;
                    neg_reg <= (span_wrap < 0);
                end
            end
            S_SPANW:
            begin
                if (drsp.done)
                    span_reg <= rem_signed;
            end
            S_PREP:
                prod_reg <= $signed({1'b0, interval_reg}) * gap_reg;
            S_DIVW:
                res_time_reg <= ft_calc;
            S_PUSH:
            begin
                if (out_free)
                begin
                    out_time_reg <= res_time_reg;
                    out_rep_reg  <= res_rep_reg;
                end
            end
            default: ;
        endcase
    end

    assign out_valid  = out_valid_reg;
    assign frame_time = out_time_reg;
    assign repeated   = out_rep_reg;

endmodule

`default_nettype wire

// ===== hdl/fdj_div.sv =====
// ----------------------------------------------------------------------------
// fdj_div
// Restoring divider, one quotient bit per cycle, shared by the sequencer.
// ----------------------------------------------------------------------------
`default_nettype none

module fdj_div (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire fdj_pkg::div_req_t req,
    output fdj_pkg::div_rsp_t     rsp
);
    import fdj_pkg::*;

    logic [DIVD_W-1:0] acc_reg;
    logic [DIVS_W-1:0] rem_reg;
    logic [DIVS_W-1:0] dvs_reg;
    logic [ITER_W-1:0] cnt_reg;
    logic              busy_reg;
    logic              done_reg;

    logic [DIVS_W:0]   trial;
    logic [DIVS_W:0]   diff;
    logic              qbit;

    always_comb
    begin
        trial = {rem_reg, acc_reg[DIVD_W-1]};
        diff  = trial - {1'b0, dvs_reg};
        qbit  = ~diff[DIVS_W];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= busy_reg && (cnt_reg == ITER_W'(1));
            if (req.start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= req.iters;
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg - ITER_W'(1);
                if (cnt_reg == ITER_W'(1))
                    busy_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (req.start)
        begin
            acc_reg <= req.dividend;
            rem_reg <= '0;
            dvs_reg <= req.divisor;
        end
        else if (busy_reg)
        begin
            acc_reg <= {acc_reg[DIVD_W-2:0], qbit};
            rem_reg <= qbit ? diff[DIVS_W-1:0] : trial[DIVS_W-1:0];
        end
    end

    assign rsp.done      = done_reg;
    assign rsp.quotient  = acc_reg;
    assign rsp.remainder = rem_reg;

endmodule

`default_nettype wire

// ===== hdl/fdj_hist.sv =====
// ----------------------------------------------------------------------------
// fdj_hist
// History ring of accepted frames: one write port, one registered read port
// that returns either the newest or the earliest stored entry.
// ----------------------------------------------------------------------------
`default_nettype none

module fdj_hist #(
    parameter int HISTORY_LEN = 64
) (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          clear,
    input  wire logic                          push,
    input  wire fdj_pkg::hist_entry_t          push_entry,
    input  wire logic                          rd_earliest,
    output fdj_pkg::hist_entry_t               rd_entry,
    output logic [$clog2(HISTORY_LEN+1)-1:0]   count
);
    import fdj_pkg::*;

    localparam int PTR_W = (HISTORY_LEN > 1) ? $clog2(HISTORY_LEN) : 1;
    localparam int CNT_W = $clog2(HISTORY_LEN+1);
    localparam int SUM_W = PTR_W + 2;

    hist_entry_t        mem [HISTORY_LEN];
    hist_entry_t        rd_reg;
    logic [PTR_W-1:0]   wp_reg;
    logic [CNT_W-1:0]   cnt_reg;

    logic [PTR_W-1:0]   lat_addr;
    logic [PTR_W-1:0]   earl_addr;
    logic [SUM_W-1:0]   earl_sum;
    logic [PTR_W-1:0]   rd_addr;
    logic [PTR_W-1:0]   wp_inc;

    always_comb
    begin
        lat_addr = (wp_reg == '0) ? PTR_W'(HISTORY_LEN - 1) : wp_reg - PTR_W'(1);
        // earliest = (wp - count) mod depth; the sum stays below twice the depth
        earl_sum = SUM_W'(wp_reg) + SUM_W'(HISTORY_LEN) - SUM_W'(cnt_reg);
        if (earl_sum >= SUM_W'(HISTORY_LEN))
            earl_addr = PTR_W'(earl_sum - SUM_W'(HISTORY_LEN));
        else
            earl_addr = PTR_W'(earl_sum);
        rd_addr = rd_earliest ? earl_addr : lat_addr;
        wp_inc  = (wp_reg == PTR_W'(HISTORY_LEN - 1)) ? '0 : wp_reg + PTR_W'(1);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wp_reg  <= '0;
            cnt_reg <= '0;
        end
        else if (clear)
        begin
            wp_reg  <= '0;
            cnt_reg <= '0;
        end
        else if (push)
        begin
            wp_reg <= wp_inc;
            if (cnt_reg != CNT_W'(HISTORY_LEN))
                cnt_reg <= cnt_reg + CNT_W'(1);
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
            mem[wp_reg] <= push_entry;
        rd_reg <= mem[rd_addr];
    end

    assign rd_entry = rd_reg;
    assign count    = cnt_reg;

endmodule

`default_nettype wire

// ===== test/fdj_stamp_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fdj_stamp_checker
// Watches the configuration port and both channels of the de-jitter core,
// keeps its own copy of the history ring and interval estimate, predicts the
// timestamp of every accepted frame and compares each result transfer with
// the oldest prediction still waiting.
// ----------------------------------------------------------------------------

module fdj_stamp_checker
    import fdj_pkg::*;
#(
    parameter int HIST_DEPTH = 64
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_wr_en,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_wr_data,
    input  logic                  in_valid,
    input  logic                  in_stall,
    input  logic                  action,
    input  logic [FRAME_W-1:0]    frame_number,
    input  logic [TIME_W-1:0]     now_time,
    input  logic                  out_valid,
    input  logic                  out_stall,
    input  logic [TIME_W-1:0]     frame_time,
    input  logic                  repeated,
    output int                    fail_count,
    output int                    outstanding
);

    localparam longint TIME_MAX = 64'h0000_FFFF_FFFF_FFFF;
    localparam longint INTV_MAX = 64'h0000_0000_FFFF_FFFF;

    typedef struct packed {
        logic [TIME_W-1:0] stamp;
        logic              rep;
    } stamp_t;

    stamp_t expected_stamps[$];

    // register copies
    logic [INTV_W-1:0] nominal_q;
    logic [MOD_W-1:0]  modulus_q;
    logic [TIME_W-1:0] start_clk_q;
    logic [TIME_W-1:0] start_ts_q;

    // history ring and interval estimate
    logic [FRAME_W-1:0] ring_frame [HIST_DEPTH];
    logic [TIME_W-1:0]  ring_ftime [HIST_DEPTH];
    logic [TIME_W-1:0]  ring_ctime [HIST_DEPTH];
    int unsigned        ring_fill;
    int unsigned        ring_wr;
    logic [INTV_W-1:0]  interval_est;

    function automatic logic [TIME_W-1:0] to_output_base(logic [TIME_W-1:0] clk_now);
        longint d;
        longint ts;
        longint sc;
        longint nw;
        ts = start_ts_q;
        sc = start_clk_q;
        nw = clk_now;
        d = ts + nw - sc;
        if (d < 0)
            return '0;
        if (d > TIME_MAX)
            return '1;
        return d[TIME_W-1:0];
    endfunction

    function automatic void ring_push(logic [FRAME_W-1:0] fn, logic [TIME_W-1:0] ft,
                                      logic [TIME_W-1:0] ct);
        ring_frame[ring_wr] = fn;
        ring_ftime[ring_wr] = ft;
        ring_ctime[ring_wr] = ct;
        ring_wr = (ring_wr + 1) % HIST_DEPTH;
        if (ring_fill < HIST_DEPTH)
            ring_fill++;
    endfunction

    // Returns 1 when the item yields a result, and the expected result in res.
    function automatic bit predict_frame_time(logic act, logic [FRAME_W-1:0] fn,
                                              logic [TIME_W-1:0] clk_now, output stamp_t res);
        logic [TIME_W-1:0] mapped;
        int unsigned       newest;
        int unsigned       oldest;
        longint gap, span, t, cspan, q, m;
        longint fn_l, newest_fn, oldest_fn, newest_ft, newest_ct, oldest_ct, iv, mapped_l;
        res = '0;
        if (act == ACT_INIT) begin
            ring_fill = 0;
            ring_wr = 0;
            interval_est = nominal_q;
            return 1'b0;
        end
        mapped = to_output_base(clk_now);
        if (ring_fill == 0) begin
            ring_push(fn, mapped, mapped);
            res.stamp = mapped;
            return 1'b1;
        end
        newest = (ring_wr + HIST_DEPTH - 1) % HIST_DEPTH;
        if (ring_fill == 1) begin
            res.stamp = mapped;
            res.rep = (ring_frame[newest] == fn);
            if (!res.rep)
                ring_push(fn, mapped, mapped);
            return 1'b1;
        end
        if (ring_frame[newest] == fn) begin
            res.stamp = ring_ftime[newest];
            res.rep = 1'b1;
            return 1'b1;
        end
        oldest = (ring_wr + HIST_DEPTH - ring_fill) % HIST_DEPTH;

        fn_l = fn;
        newest_fn = ring_frame[newest];
        oldest_fn = ring_frame[oldest];
        newest_ft = ring_ftime[newest];
        newest_ct = ring_ctime[newest];
        oldest_ct = ring_ctime[oldest];
        iv = interval_est;
        mapped_l = mapped;

        // signed remainder: frame numbers above the modulus give negative gaps
        if (modulus_q == '0) begin
            gap = fn_l - newest_fn;
            span = newest_fn - oldest_fn;
        end else begin
            m = modulus_q;
            gap = (fn_l + m - newest_fn) % m;
            span = (newest_fn - oldest_fn + m) % m;
        end
        if (span <= 0)
            span = 1;

        t = newest_ft + iv * gap;
        if (t < 0)
            t = 0;

        // re-estimate from the ring as it was before this frame is stored
        cspan = newest_ct - oldest_ct;
        if (cspan < 0)
            cspan = 0;
        q = cspan / span;
        interval_est = (q > INTV_MAX) ? '1 : q[INTV_W-1:0];

        if (t > mapped_l)
            t = mapped_l;
        ring_push(fn, t[TIME_W-1:0], mapped);
        res.stamp = t[TIME_W-1:0];
        return 1'b1;
    endfunction

    function automatic void note_failure(string what, stamp_t want, stamp_t got);
        fail_count++;
        if (fail_count <= 10)
            $display("%0t: %s: expected frame_time=%h repeated=%b, actual frame_time=%h repeated=%b",
                     $time, what, want.stamp, want.rep, got.stamp, got.rep);
    endfunction

    always @(posedge clk) begin
        stamp_t want;
        stamp_t got;
        bit     has_result;
        if (!rst_n) begin
            nominal_q = '0;
            modulus_q = '0;
            start_clk_q = '0;
            start_ts_q = '0;
            ring_fill = 0;
            ring_wr = 0;
            interval_est = '0;
            fail_count = 0;
            expected_stamps.delete();
            outstanding <= 0;
        end else begin
            if (cfg_wr_en) begin
                case (cfg_index)
                    CFG_NOMINAL_INTERVAL: nominal_q = cfg_wr_data[INTV_W-1:0];
                    CFG_FRAME_MODULUS:    modulus_q = cfg_wr_data[MOD_W-1:0];
                    CFG_START_CLOCK:      start_clk_q = cfg_wr_data[TIME_W-1:0];
                    CFG_START_TIMESTAMP:  start_ts_q = cfg_wr_data[TIME_W-1:0];
                    default: ;
                endcase
            end
            if (in_valid && !in_stall) begin
                has_result = predict_frame_time(action, frame_number, now_time, want);
                if (has_result)
                    expected_stamps.push_back(want);
            end
            if (out_valid && !out_stall) begin
                got.stamp = frame_time;
                got.rep = repeated;
                if (expected_stamps.size() == 0) begin
                    want = 'x;
                    note_failure("result transfer with nothing expected", want, got);
                end else begin
                    want = expected_stamps.pop_front();
                    if (got.stamp !== want.stamp || got.rep !== want.rep)
                        note_failure("result mismatch", want, got);
                end
            end
            outstanding <= expected_stamps.size();
        end
    end

endmodule

// ===== test/tb_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Drives the frame timestamp de-jitter core: a directed pass over the corner
// cases, then random frame runs under several register settings and three
// flow-control profiles. The checker beside the core does the comparing.
// ----------------------------------------------------------------------------

module tb_top;
    import fdj_pkg::*;

    localparam int          HISTORY_LEN  = 64;
    localparam int          DRAIN_CYCLES = 128;
    localparam int          HOLD_CYCLES  = 400;
    localparam int          PHASE_ITEMS  = 600;
    localparam int unsigned CYCLE_LIMIT  = 2_000_000;

    logic                  clk;
    logic                  rst_n;
    logic                  cfg_wr_en;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_wr_data;
    logic                  in_valid;
    logic                  in_stall;
    logic                  action;
    logic [FRAME_W-1:0]    frame_number;
    logic [TIME_W-1:0]     now_time;
    logic                  out_valid;
    logic                  out_stall;
    logic [TIME_W-1:0]     frame_time;
    logic                  repeated;

    int fail_count;
    int outstanding;

    int unsigned cycle_count = 0;
    int unsigned tx_idle_pct = 8;
    int unsigned rx_stall_pct = 74;
    logic        long_hold = 1'b0;
    int          items_sent = 0;

    // stimulus copies of the registers
    logic [INTV_W-1:0] cur_nom;
    logic [MOD_W-1:0]  cur_mod;
    logic [TIME_W-1:0] cur_sclk;

    frame_timestamp_dejitter_core #(
        .HISTORY_LEN (HISTORY_LEN)
    ) dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_wr_en    (cfg_wr_en),
        .cfg_index    (cfg_index),
        .cfg_wr_data  (cfg_wr_data),
        .in_valid     (in_valid),
        .in_stall     (in_stall),
        .action       (action),
        .frame_number (frame_number),
        .now_time     (now_time),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .frame_time   (frame_time),
        .repeated     (repeated)
    );

    fdj_stamp_checker #(
        .HIST_DEPTH (HISTORY_LEN)
    ) stamp_chk (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_wr_en    (cfg_wr_en),
        .cfg_index    (cfg_index),
        .cfg_wr_data  (cfg_wr_data),
        .in_valid     (in_valid),
        .in_stall     (in_stall),
        .action       (action),
        .frame_number (frame_number),
        .now_time     (now_time),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .frame_time   (frame_time),
        .repeated     (repeated),
        .fail_count   (fail_count),
        .outstanding  (outstanding)
    );

    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("Verification failed");
            $finish;
        end
    end

    // receiver: random stall, plus one long hold-off on request
    initial
    begin
        out_stall <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (long_hold)
            begin
                out_stall <= 1'b1;
                repeat (HOLD_CYCLES) @(posedge clk);
                long_hold = 1'b0;
                out_stall <= 1'b0;
            end
            else
                out_stall <= ($urandom_range(99) < rx_stall_pct);
        end
    end

    function automatic logic [TIME_W-1:0] random_time();
        return {$urandom, $urandom};
    endfunction

    task automatic send_item(input logic act, input logic [FRAME_W-1:0] fn,
                             input logic [TIME_W-1:0] clk_now);
        while ($urandom_range(99) < tx_idle_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        action <= act;
        frame_number <= fn;
        now_time <= clk_now;
        @(posedge clk);
        while (in_stall) @(posedge clk);
        items_sent++;
    endtask

    // an initialize yields no result, so allow the core to finish it too
    task automatic wait_idle();
        in_valid <= 1'b0;
        @(posedge clk);
        while (outstanding != 0) @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic put_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_wr_data <= data;
        @(posedge clk);
    endtask

    task automatic apply_config(input logic [INTV_W-1:0] nom, input logic [MOD_W-1:0] frame_mod,
                                input logic [TIME_W-1:0] sclk, input logic [TIME_W-1:0] sts);
        wait_idle();
        put_reg(CFG_NOMINAL_INTERVAL, CFG_DATA_W'(nom));
        put_reg(CFG_FRAME_MODULUS, CFG_DATA_W'(frame_mod));
        put_reg(CFG_START_CLOCK, sclk);
        put_reg(CFG_START_TIMESTAMP, sts);
        cfg_wr_en <= 1'b0;
        cur_nom = nom;
        cur_mod = frame_mod;
        cur_sclk = sclk;
    endtask

    task automatic random_config();
        logic [INTV_W-1:0] nom;
        logic [MOD_W-1:0]  frame_mod;
        logic [TIME_W-1:0] sclk;
        logic [TIME_W-1:0] sts;
        case ($urandom_range(7))
            0: nom = '0;
            1: nom = '1;
            default: nom = $urandom_range(32'h0064_0000, 32'h0001_0000);
        endcase
        case ($urandom_range(9))
            0, 1, 2, 3: frame_mod = '0;
            4: frame_mod = 17'd65536;
            5: frame_mod = 17'd1;
            6: frame_mod = 17'd256;
            default: frame_mod = $urandom_range(65536, 2);
        endcase
        case ($urandom_range(7))
            0: sclk = '0;
            1: sclk = '1;
            default: sclk = random_time() >> 1;
        endcase
        case ($urandom_range(5))
            0: sts = '0;
            1: sts = '1;
            2: sts = sclk;
            default: sts = random_time() >> $urandom_range(47, 1);
        endcase
        apply_config(nom, frame_mod, sclk, sts);
    endtask

    // well-formed run: optional initialize, then mostly consecutive frames
    // with a jittered clock; occasional skips, repeats, jumps and time steps
    task automatic frame_burst();
        int                len;
        int unsigned       r;
        int unsigned       fn;
        logic [INTV_W-1:0] iv;
        logic [TIME_W-1:0] tick;
        longint            step;
        len = ($urandom_range(6) == 0) ? $urandom_range(100, 65) : $urandom_range(40, 1);
        if (cur_nom >= 32'h0001_0000 && cur_nom <= 32'h00C8_0000)
            iv = cur_nom;
        else
            iv = $urandom_range(32'h0064_0000, 32'h0000_1000);
        if ($urandom_range(9) != 0)
            send_item(ACT_INIT, FRAME_W'($urandom), random_time());
        fn = $urandom_range(65535);
        tick = cur_sclk + TIME_W'($urandom);
        repeat (len)
        begin
            r = $urandom_range(99);
            if (r < 78)
                fn = fn + 1;
            else if (r < 86)
                fn = fn + $urandom_range(6, 2);
            else if (r >= 94)
                fn = $urandom_range(65535);
            fn = (cur_mod > 1) ? fn % cur_mod : fn % 65536;

            step = longint'(iv) + longint'($urandom_range(iv / 4)) - longint'(iv / 8);
            r = $urandom_range(99);
            if (r < 2)
                step = -step * longint'($urandom_range(4, 1));
            else if (r < 4)
                step = step * longint'($urandom_range(60, 2));
            tick = tick + step[TIME_W-1:0];
            send_item(ACT_FRAME, fn[FRAME_W-1:0], tick);
        end
    endtask

    initial
    begin
        int phase_goal;
        rst_n <= 1'b0;
        cfg_wr_en <= 1'b0;
        cfg_index <= CFG_NOMINAL_INTERVAL;
        cfg_wr_data <= '0;
        in_valid <= 1'b0;
        action <= ACT_FRAME;
        frame_number <= '0;
        now_time <= '0;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // reset state (zero interval), repeats at one and two entries,
        // backward frame number, clock at its top
        apply_config(32'h0021_5555, '0, '0, '0);
        send_item(ACT_FRAME, 16'd5, 48'h0000_03E8_0000);
        send_item(ACT_FRAME, 16'd5, 48'h0000_03E9_0000);
        send_item(ACT_FRAME, 16'd6, 48'h0000_0409_0000);
        send_item(ACT_FRAME, 16'd6, 48'h0000_040A_0000);
        send_item(ACT_FRAME, 16'd9, 48'h0000_0470_0000);
        send_item(ACT_INIT, 16'hFFFF, 48'hFFFF_FFFF_FFFF);
        send_item(ACT_FRAME, 16'd100, 48'h0001_0000_0000);
        send_item(ACT_FRAME, 16'd101, 48'h0001_0021_0000);
        send_item(ACT_FRAME, 16'd0, 48'h0001_0042_0000);
        send_item(ACT_FRAME, 16'hFFFF, 48'hFFFF_FFFF_FFFF);
        send_item(ACT_FRAME, 16'hFFFF, 48'h0000_0000_0000);

        // full 16-bit wrap modulus, largest interval, clock mapped to zero
        apply_config('1, 17'd65536, '1, '0);
        send_item(ACT_INIT, 16'd0, 48'h0);
        send_item(ACT_FRAME, 16'hFFFF, 48'hFFFF_FFFF_FFFF);
        send_item(ACT_FRAME, 16'd0, 48'hFFFF_FFFF_FFFF);
        send_item(ACT_FRAME, 16'd1, 48'h8000_0000_0000);
        send_item(ACT_FRAME, 16'd3, 48'h0);

        // wrap past the modulus, saturated interval, frame above modulus
        apply_config('0, 17'd1000, '0, '0);
        send_item(ACT_INIT, 16'h1234, 48'h5555_AAAA_5555);
        send_item(ACT_FRAME, 16'd998, 48'h0);
        send_item(ACT_FRAME, 16'd999, 48'h8000_0000_0000);
        send_item(ACT_FRAME, 16'd2, 48'h8000_0000_0100);
        send_item(ACT_FRAME, 16'hFFFF, 48'h8000_0000_0200);
        send_item(ACT_FRAME, 16'd5, 48'h8000_0000_0300);

        // modulus of one, clock saturating high
        apply_config(32'd12345, 17'd1, '0, '1);
        send_item(ACT_INIT, 16'hAAAA, 48'hAAAA_5555_AAAA);
        send_item(ACT_FRAME, 16'd7, 48'd1);
        send_item(ACT_FRAME, 16'd8, 48'd2);
        send_item(ACT_FRAME, 16'd9, 48'd3);

        for (int ph = 0; ph < 3; ph++)
        begin
            case (ph)
                0:
                begin
                    tx_idle_pct = 8;
                    rx_stall_pct = 74;
                end
                1:
                begin
                    tx_idle_pct = 74;
                    rx_stall_pct = 8;
                end
                default:
                begin
                    tx_idle_pct = 0;
                    rx_stall_pct = 0;
                end
            endcase
            for (int seg = 0; seg < 3; seg++)
            begin
                random_config();
                // back-pressure: the core fills up while the sender keeps offering
                if (ph == 2 && seg == 0)
                    long_hold = 1'b1;
                phase_goal = items_sent + PHASE_ITEMS / 3;
                while (items_sent < phase_goal)
                begin
                    if ($urandom_range(99) < 85)
                        frame_burst();
                    else
                        repeat ($urandom_range(5, 1))
                            send_item(($urandom_range(4) == 0) ? ACT_INIT : ACT_FRAME,
                                      FRAME_W'($urandom), random_time());
                end
            end
        end

        wait_idle();
        if (fail_count == 0 && outstanding == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

endmodule
